/* hdl/pas_pkg.sv */
// Package for the pitot airspeed block: field types, transaction structs,
// register codes, reset values and the fixed-point constants.
// No dependencies; every other file of the block uses it.
package pas_pkg;

    localparam int ADC_BITS  = 10;
    localparam int ADC_W     = 10;
    localparam int AVG_COUNT = 8;
    localparam int AVG_SHIFT = $clog2(AVG_COUNT);
    localparam int SUM_W     = ADC_W + AVG_SHIFT;

    localparam logic [63:0] K_Q16_FULL = (64'd6888785 << 10) >> ADC_BITS;
    localparam int K_W        = 23;
    localparam int MUL_W      = ADC_W + K_W;
    localparam int FRAC_BITS  = 16;
    localparam int RAD_W      = MUL_W - FRAC_BITS;
    localparam int ROOT_W     = (RAD_W + 1) / 2;
    localparam int RAD_PAD_W  = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam logic [K_W-1:0] K_Q16 = K_Q16_FULL[K_W-1:0];

    localparam int SPEED_W     = 9;
    localparam int PERIOD_W    = 8;
    localparam int COUNTDOWN_W = 9;
    localparam int REG_IDX_W   = 3;

    localparam logic [PERIOD_W-1:0] RST_REFRESH_PERIOD = 8'd10;
    localparam logic [PERIOD_W-1:0] RST_START_OFFSET   = 8'd0;
    localparam logic [ADC_W-1:0]    RST_SETTLE_TICKS   = 10'd500;
    localparam logic [ADC_W-1:0]    RST_FAIL_LEVEL     = 10'd1003;
    localparam logic [SPEED_W-1:0]  RST_MIN_SPEED      = 9'd20;

    typedef logic [ADC_W-1:0] t_adc;
    typedef logic [AVG_COUNT-1:0][ADC_W-1:0] t_sample_vec;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_REFRESH_PERIOD = 3'd0,
        REG_START_OFFSET   = 3'd1,
        REG_SETTLE_TICKS   = 3'd2,
        REG_FAIL_LEVEL     = 3'd3,
        REG_MIN_SPEED      = 3'd4
    } t_reg_idx;

    typedef struct packed {
        t_adc check_sample;
        t_adc sample_0;
        t_adc sample_1;
        t_adc sample_2;
        t_adc sample_3;
        t_adc sample_4;
        t_adc sample_5;
        t_adc sample_6;
        t_adc sample_7;
    } t_in_item;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_kmh;
        logic               sensor_failure;
    } t_out_item;

    typedef struct packed {
        logic [REG_IDX_W-1:0] reg_idx;
        logic [ADC_W-1:0]     wdata;
    } t_cfg_write;

endpackage

/* hdl/pas_if.sv */
// Channel interfaces of the pitot airspeed block: input ticks, results and
// configuration writes, each with valid, ready and a payload struct.
// Depends on pas_pkg.
interface pas_in_if;
    logic              valid;
    logic              ready;
    pas_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pas_out_if;
    logic               valid;
    logic               ready;
    pas_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pas_cfg_if;
    logic                valid;
    logic                ready;
    pas_pkg::t_cfg_write data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/pitot_airspeed_from_pressure.sv */
// Top level of the pitot airspeed block: tick control, settling, refresh
// countdown, configuration registers and the result register.
// Depends on pas_pkg, pas_if, pas_avg, pas_mul and pas_sqrt.
//
// Each transaction on i_in is one 10 ms tick carrying a check sample and
// eight ADC samples. During settling a tick only stores the check sample as
// the zero-speed reference. After that, a result leaves on o_out once every
// refresh_period ticks, the first interval lengthened by start_offset.
// A tick that gives a result occupies the block until the result is valid on
// o_out: the samples are summed, then scaled in the bit-serial multiplier,
// then passed through the square-root unit; a failure result skips these
// steps and goes straight to the result stage. i_in is ready only while no
// tick is being worked on and no configuration transaction is offered.
// The result register holds one transaction; while o_out is stalled a new
// tick can still be taken, but its result waits until the register frees.
// i_cfg is always ready; the user must see that it is written only while
// the block is idle, as the block itself does not enforce this.
// Reset is synchronous and restores the register defaults, clears settling
// and reloads the countdown.
module pitot_airspeed_from_pressure (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pas_cfg_if.sink     i_cfg,
    pas_in_if.sink      i_in,
    pas_out_if.source   o_out
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_MUL,
        S_SQRT,
        S_HOLD
    } t_state;

    t_state                              r_state;
    logic [pas_pkg::PERIOD_W-1:0]        r_refresh_period;
    logic [pas_pkg::PERIOD_W-1:0]        r_start_offset;
    pas_pkg::t_adc                       r_settle_ticks;
    pas_pkg::t_adc                       r_fail_level;
    logic [pas_pkg::SPEED_W-1:0]         r_min_speed;
    pas_pkg::t_adc                       r_settle_count;
    logic [pas_pkg::COUNTDOWN_W-1:0]     r_countdown;
    pas_pkg::t_adc                       r_ref_level;
    pas_pkg::t_out_item                  r_res;
    pas_pkg::t_out_item                  r_out;
    logic                                r_out_valid;

    logic                                w_in_acc;
    logic                                w_cfg_acc;
    logic                                w_out_free;
    logic                                w_settling;
    logic                                w_fail;
    logic                                w_avg_start;
    logic                                w_avg_done;
    logic                                w_mul_done;
    logic                                w_sqrt_done;
    pas_pkg::t_adc                       w_diff;
    logic [pas_pkg::RAD_W-1:0]           w_prod;
    logic [pas_pkg::ROOT_W-1:0]          w_root;
    pas_pkg::t_sample_vec                w_samples;

    assign i_in.ready  = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_settling  = (r_settle_count < r_settle_ticks);
    assign w_fail      = (i_in.data.check_sample >= r_fail_level);
    assign w_avg_start = w_in_acc && !w_settling &&
                         (r_countdown == pas_pkg::COUNTDOWN_W'(1)) && !w_fail;

    assign w_samples[0] = i_in.data.sample_0;
    assign w_samples[1] = i_in.data.sample_1;
    assign w_samples[2] = i_in.data.sample_2;
    assign w_samples[3] = i_in.data.sample_3;
    assign w_samples[4] = i_in.data.sample_4;
    assign w_samples[5] = i_in.data.sample_5;
    assign w_samples[6] = i_in.data.sample_6;
    assign w_samples[7] = i_in.data.sample_7;

    pas_avg u_avg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_avg_start),
        .i_samples (w_samples),
        .i_ref     (r_ref_level),
        .o_done    (w_avg_done),
        .o_diff    (w_diff)
    );

    pas_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_avg_done),
        .i_diff  (w_diff),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    pas_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_done),
        .i_rad   (w_prod),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_refresh_period <= pas_pkg::RST_REFRESH_PERIOD;
            r_start_offset   <= pas_pkg::RST_START_OFFSET;
            r_settle_ticks   <= pas_pkg::RST_SETTLE_TICKS;
            r_fail_level     <= pas_pkg::RST_FAIL_LEVEL;
            r_min_speed      <= pas_pkg::RST_MIN_SPEED;
            r_settle_count   <= '0;
            r_ref_level      <= '0;
            r_countdown      <= pas_pkg::COUNTDOWN_W'(pas_pkg::RST_REFRESH_PERIOD)
                              + pas_pkg::COUNTDOWN_W'(pas_pkg::RST_START_OFFSET);
            r_out_valid      <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && (r_state != S_HOLD)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        priority if (w_settling) begin
                            r_settle_count <= r_settle_count + 1'b1;
                            r_ref_level    <= i_in.data.check_sample;
                        end else if (r_countdown != '0) begin
                            if (r_countdown == pas_pkg::COUNTDOWN_W'(1)) begin
                                r_countdown <= pas_pkg::COUNTDOWN_W'(r_refresh_period);
                                if (w_fail) begin
                                    r_res.speed_kmh      <= '0;
                                    r_res.sensor_failure <= 1'b1;
                                    r_state              <= S_HOLD;
                                end else begin
                                    r_state <= S_AVG;
                                end
                            end else begin
                                r_countdown <= r_countdown - 1'b1;
                            end
                        end
                    end
                end
                S_AVG: begin
                    if (w_avg_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_sqrt_done) begin
                        r_res.speed_kmh      <= (w_root < r_min_speed) ? '0 : w_root;
                        r_res.sensor_failure <= 1'b0;
                        r_state              <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_cfg_acc) begin
                unique case (i_cfg.data.reg_idx)
                    pas_pkg::REG_REFRESH_PERIOD: begin
                        r_refresh_period <= i_cfg.data.wdata[pas_pkg::PERIOD_W-1:0];
                        r_countdown <=
                            pas_pkg::COUNTDOWN_W'(i_cfg.data.wdata[pas_pkg::PERIOD_W-1:0])
                          + pas_pkg::COUNTDOWN_W'(r_start_offset);
                    end
                    pas_pkg::REG_START_OFFSET: begin
                        r_start_offset <= i_cfg.data.wdata[pas_pkg::PERIOD_W-1:0];
                        r_countdown <=
                            pas_pkg::COUNTDOWN_W'(r_refresh_period)
                          + pas_pkg::COUNTDOWN_W'(i_cfg.data.wdata[pas_pkg::PERIOD_W-1:0]);
                    end
                    pas_pkg::REG_SETTLE_TICKS: begin
                        r_settle_ticks <= i_cfg.data.wdata;
                    end
                    pas_pkg::REG_FAIL_LEVEL: begin
                        r_fail_level <= i_cfg.data.wdata;
                    end
                    pas_pkg::REG_MIN_SPEED: begin
                        r_min_speed <= i_cfg.data.wdata[pas_pkg::SPEED_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_fail_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.sensor_failure) |-> (r_out.speed_kmh == '0))
        else $error("failure result carries a non-zero speed");

    a_speed_above_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.sensor_failure && (r_out.speed_kmh != '0))
            |-> (r_out.speed_kmh >= r_min_speed))
        else $error("reported speed is below the minimum speed");

    a_settle_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_settling) |=> (r_state == S_IDLE))
        else $error("a settling tick started a computation");

    a_result_after_sqrt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && w_sqrt_done) |=> (r_state == S_HOLD))
        else $error("square-root result was not taken into the result stage");
endmodule

/* hdl/pas_avg.sv */
// Word-serial averager: adds one sample per cycle, then clamps the mean
// against the reference level and gives the difference.
// Depends on pas_pkg.
module pas_avg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  pas_pkg::t_sample_vec i_samples,
    input  pas_pkg::t_adc        i_ref,
    output logic                 o_done,
    output pas_pkg::t_adc        o_diff
);
    localparam logic [pas_pkg::AVG_SHIFT-1:0] LAST =
        pas_pkg::AVG_SHIFT'(pas_pkg::AVG_COUNT - 1);

    logic                             r_busy;
    logic                             r_done;
    logic [pas_pkg::AVG_SHIFT-1:0]    r_cnt;
    logic [pas_pkg::SUM_W-1:0]        r_sum;
    pas_pkg::t_sample_vec             r_shift;
    pas_pkg::t_adc                    r_diff;
    logic [pas_pkg::SUM_W-1:0]        w_sum;
    pas_pkg::t_adc                    w_avg;

    assign w_sum = r_sum + pas_pkg::SUM_W'(r_shift[0]);
    assign w_avg = w_sum[pas_pkg::SUM_W-1 -: pas_pkg::ADC_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_samples;
            r_sum   <= '0;
        end else if (r_busy) begin
            r_shift <= r_shift >> pas_pkg::ADC_W;
            r_sum   <= w_sum;
            r_diff  <= (w_avg > i_ref) ? (w_avg - i_ref) : '0;
        end
    end

    assign o_done = r_done;
    assign o_diff = r_diff;
endmodule

/* hdl/pas_mul.sv */
// Bit-serial multiplier: scales the pressure difference by the Q16 speed
// constant, one multiplier bit per cycle, most significant bit first.
// Depends on pas_pkg.
module pas_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  pas_pkg::t_adc               i_diff,
    output logic                        o_done,
    output logic [pas_pkg::RAD_W-1:0]   o_prod
);
    localparam int CNT_W = $clog2(pas_pkg::ADC_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(pas_pkg::ADC_W - 1);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    pas_pkg::t_adc              r_mult;
    logic [pas_pkg::MUL_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mult <= i_diff;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_mult <= r_mult << 1;
            r_acc  <= (r_acc << 1) + (r_mult[pas_pkg::ADC_W-1] ?
                      pas_pkg::MUL_W'(pas_pkg::K_Q16) : '0);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc[pas_pkg::MUL_W-1 -: pas_pkg::RAD_W];
endmodule

/* hdl/pas_sqrt.sv */
// Digit-by-digit integer square root, two radicand bits per cycle, giving
// the floor of the root of the scaled pressure difference.
// Depends on pas_pkg.
module pas_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pas_pkg::RAD_W-1:0]     i_rad,
    output logic                          o_done,
    output logic [pas_pkg::ROOT_W-1:0]    o_root
);
    localparam int CNT_W = $clog2(pas_pkg::ROOT_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(pas_pkg::ROOT_W - 1);

    logic                              r_busy;
    logic                              r_done;
    logic [CNT_W-1:0]                  r_cnt;
    logic [pas_pkg::RAD_PAD_W-1:0]     r_rad;
    logic [pas_pkg::REM_W-1:0]         r_rem;
    logic [pas_pkg::ROOT_W-1:0]        r_root;
    logic [pas_pkg::REM_W+1:0]         w_cur;
    logic [pas_pkg::REM_W+1:0]         w_trial;
    logic                              w_fit;

    assign w_cur   = {r_rem, r_rad[pas_pkg::RAD_PAD_W-1 -: 2]};
    assign w_trial = (pas_pkg::REM_W + 2)'({r_root, 2'b01});
    assign w_fit   = (w_cur >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= pas_pkg::RAD_PAD_W'(i_rad);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= r_rad << 2;
            if (w_fit) begin
                r_rem  <= pas_pkg::REM_W'(w_cur - w_trial);
                r_root <= {r_root[pas_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= pas_pkg::REM_W'(w_cur);
                r_root <= {r_root[pas_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
